### hdl/vwcf_pkg.sv
`default_nettype none
package vwcf_pkg;

  localparam int unsigned DATA_WIDTH = 64;
  localparam int unsigned WIDTH_BITS = 7;
  localparam int unsigned OP_BITS = 4;
  localparam int unsigned DIV_STEPS = 8;
  localparam int unsigned DIV_BITS_PER_STEP = DATA_WIDTH / DIV_STEPS;

  typedef enum logic [OP_BITS-1:0] {
    OP_ABS = 4'd0,
    OP_AND = 4'd1,
    OP_CHG = 4'd2,
    OP_DIV = 4'd3,
    OP_MAX = 4'd4,
    OP_MIN = 4'd5,
    OP_SUB = 4'd6,
    OP_MUL = 4'd7,
    OP_NEG = 4'd8,
    OP_NOT = 4'd9,
    OP_OR  = 4'd10,
    OP_ADD = 4'd11,
    OP_REM = 4'd12,
    OP_SHL = 4'd13,
    OP_SHR = 4'd14,
    OP_XOR = 4'd15
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic                  wrap;
    logic                  sgn;
    logic [WIDTH_BITS-1:0] width;
    logic                  refuse;
  } ctl_t;

endpackage
`default_nettype wire

### hdl/vwcf_div.sv
`default_nettype none
module vwcf_div (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  input  wire [vwcf_pkg::DATA_WIDTH-1:0]     dividend,
  input  wire [vwcf_pkg::DATA_WIDTH-1:0]     divisor,
  output logic [vwcf_pkg::DATA_WIDTH-1:0]    quotient,
  output logic [vwcf_pkg::DATA_WIDTH-1:0]    remainder,
  output logic                               out_valid
);
  localparam int unsigned W = vwcf_pkg::DATA_WIDTH;
  localparam int unsigned S = vwcf_pkg::DIV_STEPS;
  localparam int unsigned K = vwcf_pkg::DIV_BITS_PER_STEP;

  // restoring divider, K quotient bits per stage
  logic [W-1:0] q_r [S];
  logic [W-1:0] rm_r [S];
  logic [W-1:0] d_r [S];
  logic         v_r [S];

  for (genvar s = 0; s < S; s++) begin : g_stage
    logic [W-1:0] q_in;
    logic [W-1:0] rm_in;
    logic [W-1:0] d_in;
    logic         v_in;
    logic [W-1:0] q_nxt;
    logic [W-1:0] rm_nxt;
    if (s == 0) begin : g_first
      assign q_in  = dividend;
      assign rm_in = '0;
      assign d_in  = divisor;
      assign v_in  = in_valid;
    end else begin : g_next
      assign q_in  = q_r[s-1];
      assign rm_in = rm_r[s-1];
      assign d_in  = d_r[s-1];
      assign v_in  = v_r[s-1];
    end
    always_comb begin
      logic [W:0]   t;
      logic [W-1:0] q;
      logic [W-1:0] rm;
      q  = q_in;
      rm = rm_in;
      for (int i = 0; i < K; i++) begin
        t = {rm, q[W-1]};
        q = {q[W-2:0], 1'b0};
        if (t >= {1'b0, d_in}) begin
          t = t - {1'b0, d_in};
          q[0] = 1'b1;
        end
        rm = t[W-1:0];
      end
      q_nxt  = q;
      rm_nxt = rm;
    end
    always_ff @(posedge clk) begin
      q_r[s]  <= q_nxt;
      rm_r[s] <= rm_nxt;
      d_r[s]  <= d_in;
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_in;
      end
    end
  end

  assign quotient  = q_r[S-1];
  assign remainder = rm_r[S-1];
  assign out_valid = v_r[S-1];
endmodule
`default_nettype wire

### hdl/variable_width_constant_fold_alu.sv
`default_nettype none
// channel | ports                                                   | direction
// input   | start, busy (out), in_opcode, in_wrap_mode,              | in
//         | in_is_signed, in_width, in_operand_a, in_operand_b       |
// result  | out_valid, out_folded, out_value                         | out
// One transaction per cycle; busy is always low. Stages in order: one
// operand stage, eight divider stages (8 quotient bits each, the product sum
// and a delay line run beside them), one width check stage, one output register.
// The multiplier is four 32x32 partial products registered before summing.
// Reset clears all valid bits. The receiver cannot stall.
module variable_width_constant_fold_alu (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire  [vwcf_pkg::OP_BITS-1:0]       in_opcode,
  input  wire                                in_wrap_mode,
  input  wire                                in_is_signed,
  input  wire  [vwcf_pkg::WIDTH_BITS-1:0]    in_width,
  input  wire  [vwcf_pkg::DATA_WIDTH-1:0]    in_operand_a,
  input  wire  [vwcf_pkg::DATA_WIDTH-1:0]    in_operand_b,
  output logic                               out_valid,
  output logic                               out_folded,
  output logic [vwcf_pkg::DATA_WIDTH-1:0]    out_value
);
  localparam int unsigned W = vwcf_pkg::DATA_WIDTH;
  localparam int unsigned H = W / 2;
  localparam int unsigned DL = vwcf_pkg::DIV_STEPS;

  assign busy = 1'b0;

  // stage 1: decode, refusals, partial products, simple results
  vwcf_pkg::ctl_t ctl_nxt, ctl1_r;
  logic [2*W-1:0] c1_nxt, c1_r;
  logic [W-1:0]   pp0_r, pp1_r, pp2_r, pp3_r;
  logic           msgn_r, v1_r;
  logic [W-1:0]   a_s, b_s, ma, mb;

  always_comb begin
    vwcf_pkg::op_t op;
    logic ok;
    op  = vwcf_pkg::op_t'(in_opcode);
    a_s = in_operand_a;
    b_s = (op == vwcf_pkg::OP_ABS || op == vwcf_pkg::OP_CHG ||
           op == vwcf_pkg::OP_NEG || op == vwcf_pkg::OP_NOT) ? '0 : in_operand_b;
    ma  = a_s[W-1] ? (~a_s + 1'b1) : a_s;
    mb  = b_s[W-1] ? (~b_s + 1'b1) : b_s;
    ok  = (in_width != '0) && (in_width <= W[6:0]);
    if (!in_is_signed && (a_s[W-1] || b_s[W-1])) ok = 1'b0;
    c1_nxt = {{W{a_s[W-1]}}, a_s};
    case (op)
      vwcf_pkg::OP_ABS: c1_nxt = a_s[W-1] ? -{{W{a_s[W-1]}}, a_s} : {{W{1'b0}}, a_s};
      vwcf_pkg::OP_AND: begin
        ok = ok && !a_s[W-1] && !b_s[W-1];
        c1_nxt = {{W{1'b0}}, a_s & b_s};
      end
      vwcf_pkg::OP_OR: begin
        ok = ok && !a_s[W-1] && !b_s[W-1];
        c1_nxt = {{W{1'b0}}, a_s | b_s};
      end
      vwcf_pkg::OP_XOR: begin
        ok = ok && !a_s[W-1] && !b_s[W-1];
        c1_nxt = {{W{1'b0}}, a_s ^ b_s};
      end
      vwcf_pkg::OP_CHG: c1_nxt = {{W{a_s[W-1]}}, a_s};
      vwcf_pkg::OP_DIV, vwcf_pkg::OP_REM:
        ok = ok && !a_s[W-1] && !b_s[W-1] && (b_s != '0);
      vwcf_pkg::OP_MAX: c1_nxt = ($signed(a_s) >= $signed(b_s)) ?
                                 {{W{a_s[W-1]}}, a_s} : {{W{b_s[W-1]}}, b_s};
      vwcf_pkg::OP_MIN: c1_nxt = ($signed(a_s) < $signed(b_s)) ?
                                 {{W{a_s[W-1]}}, a_s} : {{W{b_s[W-1]}}, b_s};
      vwcf_pkg::OP_SUB: c1_nxt = {{W{a_s[W-1]}}, a_s} - {{W{b_s[W-1]}}, b_s};
      vwcf_pkg::OP_ADD: c1_nxt = {{W{a_s[W-1]}}, a_s} + {{W{b_s[W-1]}}, b_s};
      vwcf_pkg::OP_NEG: c1_nxt = -{{W{a_s[W-1]}}, a_s};
      vwcf_pkg::OP_NOT: begin
        ok = ok && !in_is_signed && in_wrap_mode;
        c1_nxt = {{W{a_s[W-1]}}, ~a_s};
        c1_nxt[2*W-1:W] = {W{~a_s[W-1]}};
      end
      vwcf_pkg::OP_SHL: begin
        ok = ok && !in_is_signed && in_wrap_mode;
        c1_nxt = {{W{1'b0}}, (b_s < W) ? (a_s << b_s[$clog2(W)-1:0]) : {W{1'b0}}};
        c1_nxt[2*W-1:W] = {W{c1_nxt[W-1]}};
      end
      vwcf_pkg::OP_SHR: begin
        ok = ok && !in_is_signed && in_wrap_mode;
        c1_nxt = {{W{1'b0}}, (b_s < W) ? (a_s >> b_s[$clog2(W)-1:0]) : {W{1'b0}}};
        c1_nxt[2*W-1:W] = {W{c1_nxt[W-1]}};
      end
      default: ;
    endcase
    ctl_nxt.op     = op;
    ctl_nxt.wrap   = in_wrap_mode;
    ctl_nxt.sgn    = in_is_signed;
    ctl_nxt.width  = in_width;
    ctl_nxt.refuse = !ok;
  end

  always_ff @(posedge clk) begin
    ctl1_r <= ctl_nxt;
    c1_r   <= c1_nxt;
    pp0_r  <= ma[H-1:0] * mb[H-1:0];
    pp1_r  <= ma[H-1:0] * mb[W-1:H];
    pp2_r  <= ma[W-1:H] * mb[H-1:0];
    pp3_r  <= ma[W-1:H] * mb[W-1:H];
    msgn_r <= a_s[W-1] ^ b_s[W-1];
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
  end

  // stage 2: product sum and sign
  vwcf_pkg::ctl_t ctl2_r;
  logic [2*W-1:0] c2_r;
  always_ff @(posedge clk) begin
    logic [2*W-1:0] p;
    p = {{W{1'b0}}, pp0_r} + ({{W{1'b0}}, pp1_r} << H) + ({{W{1'b0}}, pp2_r} << H)
        + {pp3_r, {W{1'b0}}};
    ctl2_r <= ctl1_r;
    c2_r   <= (ctl1_r.op == vwcf_pkg::OP_MUL) ? (msgn_r ? -p : p) : c1_r;
  end

  // divider runs in parallel, result delay line matches it
  logic [W-1:0] in_hold_a_r, in_hold_b_r;
  always_ff @(posedge clk) begin
    in_hold_a_r <= a_s;
    in_hold_b_r <= (b_s == '0) ? {{(W-1){1'b0}}, 1'b1} : b_s;
  end

  logic [W-1:0] quo, rem;
  logic         dv;
  vwcf_div u_div (
    .clk(clk), .rst_n(rst_n), .in_valid(v1_r),
    .dividend(in_hold_a_r),
    .divisor(in_hold_b_r),
    .quotient(quo), .remainder(rem), .out_valid(dv)
  );

  vwcf_pkg::ctl_t ctl_d_r [DL-1];
  logic [2*W-1:0] c_d_r [DL-1];
  always_ff @(posedge clk) begin
    ctl_d_r[0] <= ctl2_r;
    c_d_r[0]   <= c2_r;
    for (int i = 1; i < DL - 1; i++) begin
      ctl_d_r[i] <= ctl_d_r[i-1];
      c_d_r[i]   <= c_d_r[i-1];
    end
  end

  // stage: width check
  logic           ok_r, v_chk_r;
  logic [W-1:0]   val_r;
  always_ff @(posedge clk) begin
    vwcf_pkg::ctl_t c;
    logic [2*W-1:0] r;
    logic [W-1:0]   mask, ext;
    logic           ok;
    c = ctl_d_r[DL-2];
    r = c_d_r[DL-2];
    if (c.op == vwcf_pkg::OP_DIV) r = {{W{1'b0}}, quo};
    if (c.op == vwcf_pkg::OP_REM) r = {{W{1'b0}}, rem};
    mask = (c.width >= W[6:0]) ? '1 : ((W'(1) << c.width[$clog2(W)-1:0]) - 1'b1);
    ok = !c.refuse;
    if (c.sgn) begin
      ext = r[W-1:0] & mask;
      if (c.width < W[6:0] && c.width != '0 &&
          ext[c.width[$clog2(W)-1:0] - 1'b1]) ext = ext | ~mask;
      if ((r[2*W-1:W] != {W{r[W-1]}}) || (ext != r[W-1:0])) ok = 1'b0;
      val_r <= ok ? r[W-1:0] : '0;
    end else begin
      if (((r[2*W-1]) || (r[2*W-1:W] != '0) || ((r[W-1:0] & ~mask) != '0)) && !c.wrap)
        ok = 1'b0;
      val_r <= ok ? (r[W-1:0] & mask) : '0;
    end
    ok_r <= ok;
    if (!rst_n) begin
      v_chk_r <= 1'b0;
    end else begin
      v_chk_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    out_folded <= ok_r;
    out_value  <= val_r;
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_chk_r;
    end
  end
endmodule
`default_nettype wire

### hdl/vwcf_checker.sv
`default_nettype none
module vwcf_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              start,
  input wire                              busy,
  input wire                              out_valid,
  input wire                              out_folded,
  input wire [vwcf_pkg::DATA_WIDTH-1:0]   out_value
);
  a_nobusy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy high");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_folded |-> out_value == '0)
    else $error("refused result not zero");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##11 out_valid)
    else $error("result missing");
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    !start |-> ##11 !out_valid)
    else $error("spurious result");
endmodule

bind variable_width_constant_fold_alu vwcf_checker u_vwcf_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_folded(out_folded), .out_value(out_value)
);
`default_nettype wire
